### hdl/tbem_pkg.sv
// shared types, constants and arithmetic helpers of the three-band energy meter
package tbem_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned CoefFracBits = 30;
  localparam int unsigned StateBits = 48;
  localparam int unsigned CountBits = 32;
  localparam int unsigned SumBits = 63;
  localparam int unsigned Bands = 3;
  localparam int unsigned BandBits = 2;
  localparam int unsigned ProdBits = 51;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 32;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CHANNELS  = 3'd0,
    CFG_BASS_GAIN = 3'd1,
    CFG_BASS_COS  = 3'd2,
    CFG_MID_GAIN  = 3'd3,
    CFG_MID_COS   = 3'd4,
    CFG_HIGH_GAIN = 3'd5,
    CFG_HIGH_COS  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_sample;
    logic signed [SampleBits-1:0] right_sample;
    logic                         block_end;
  } in_beat_t;

  typedef struct packed {
    logic [SumBits-1:0]    total_square_sum;
    logic [SampleBits-1:0] peak_magnitude;
    logic [SumBits-1:0]    bass_square_sum;
    logic [SumBits-1:0]    mid_square_sum;
    logic [SumBits-1:0]    high_square_sum;
    logic [CountBits-1:0]  sample_count;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]                   channel_count;
    logic [Bands-1:0][29:0]       gain;
    logic [Bands-1:0][31:0]       cos;
  } cfg_t;

  // band state word as kept in the state memory
  typedef struct packed {
    logic signed [StateBits-1:0] z1;
    logic signed [StateBits-1:0] z2;
    logic [SumBits-1:0]          energy;
  } band_word_t;

  localparam int unsigned WordBits = $bits(band_word_t);

  // saturating accumulate of a square into a 63-bit sum
  function automatic logic [SumBits-1:0] sum_sat(logic [SumBits-1:0] s, logic [30:0] a);
    logic [SumBits:0] t;
    t = {1'b0, s} + {{(SumBits-30){1'b0}}, a};
    return t[SumBits] ? {SumBits{1'b1}} : t[SumBits-1:0];
  endfunction

  // clamp a 52-bit signed value to the filter state width
  function automatic logic signed [StateBits-1:0] clamp_state(logic signed [51:0] v);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sh0_7FFF_FFFF_FFFF;
    lo = -hi - 52'sd1;
    if (v > hi) return hi[StateBits-1:0];
    else if (v < lo) return lo[StateBits-1:0];
    else return v[StateBits-1:0];
  endfunction

  // round half up at the binary point and clamp to a sample
  function automatic logic signed [SampleBits-1:0] round_sample(logic signed [63:0] acc);
    logic signed [63:0] r;
    r = (acc + 64'sd536870912) >>> CoefFracBits;
    if (r > 64'sd32767) return 16'sh7FFF;
    else if (r < -64'sd32768) return 16'sh8000;
    else return r[SampleBits-1:0];
  endfunction

endpackage

### hdl/three_band_energy_meter_top.sv
// three-band energy meter: sequencer, shared multiplier and band state memory
//
//  channel | direction | handshake          | beat
//  in      | input     | in_valid/in_ready  | left, right sample, block end
//  out     | output    | out_valid/out_ready| sums, peak, sample count
//  cfg     | input     | cfg_valid/cfg_ready| register index, data
//
// from accept to the next ready a sample passes the accept step in S_IDLE,
// S_TOT for peak, count and the total square, then S_RD to S_WR per band on
// the single 34x17 multiplier, which serves four products per band in turn.
// after a block end sample, S_IDLE loads the result register before new input.
// the band state (z1, z2, energy) sits in a 3-entry ram; per-entry valid bits
// make an unwritten or cleared entry read as zero, so no clearing pass is run.
// reset clears all control state; cfg is always ready.
// a result waits in the output register; a second block end stalls only while
// that register is still full.
module three_band_energy_meter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tbem_pkg::in_beat_t                in_beat_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tbem_pkg::out_beat_t               out_beat_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbem_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [tbem_pkg::CfgDataBits-1:0]  cfg_data_i
);
  import tbem_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_TOT, S_RD, S_ACC, S_A1, S_A2, S_YY, S_WR
  } state_e;
  localparam state_e S_OUT_DUMMY = S_IDLE;

  cfg_t cfg;
  state_e state_q;
  logic out_pend_q;
  logic [BandBits-1:0] band_q;
  logic [Bands-1:0] valid_q;
  logic signed [SampleBits-1:0] x_q;
  logic [SampleBits-1:0] mag_q;
  logic blk_q;
  logic signed [ProdBits-1:0] prod_q;
  logic signed [ProdBits-1:0] bx_q;
  logic signed [SampleBits-1:0] y_q;
  logic signed [StateBits-1:0] z1n_q;
  logic signed [StateBits-1:0] z2n_q;
  logic [SumBits-1:0] total_q;
  logic [SampleBits-1:0] peak_q;
  logic [CountBits-1:0] count_q;
  logic [Bands-1:0][SumBits-1:0] esum_q;
  logic out_valid_q;
  out_beat_t out_q;

  band_word_t rd_raw;
  band_word_t rd_word;
  band_word_t wr_word;
  logic wr_en;

  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [ProdBits-1:0] mul_p;
  logic signed [SampleBits:0] mono_sum;
  logic signed [SampleBits-1:0] mono;
  logic [SampleBits:0] mono_abs;
  logic signed [33:0] a2;
  logic [SumBits-1:0] e_new;
  logic load_out;
  logic finish;

  assign cfg_ready_o = 1'b1;

  tbem_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  tbem_ram #(.WIDTH(WordBits), .DEPTH(Bands)) u_ram (
    .clk_i, .we_i(wr_en), .waddr_i(band_q), .wdata_i(wr_word),
    .raddr_i(band_q), .rdata_o(rd_raw)
  );

  // cleared entries read as zero
  assign rd_word = valid_q[band_q] ? rd_raw : '0;

  // mono reduction of the incoming beat
  assign mono_sum = {in_beat_i.left_sample[SampleBits-1], in_beat_i.left_sample}
                  + {in_beat_i.right_sample[SampleBits-1], in_beat_i.right_sample};
  assign mono = (cfg.channel_count == 2'd2) ? mono_sum[SampleBits:1] : in_beat_i.left_sample;
  assign mono_abs = mono[SampleBits-1] ? -{mono[SampleBits-1], mono} : {1'b0, mono};

  assign a2 = 34'sd1073741824 - $signed({3'b000, cfg.gain[band_q], 1'b0});

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_TOT: begin
        mul_a = {18'd0, mag_q};
        mul_b = {1'b0, mag_q};
      end
      S_RD: begin
        mul_a = {4'd0, cfg.gain[band_q]};
        mul_b = {x_q[SampleBits-1], x_q};
      end
      S_A1: begin
        mul_a = {{2{cfg.cos[band_q][31]}}, cfg.cos[band_q]};
        mul_b = {y_q[SampleBits-1], y_q};
      end
      S_A2: begin
        mul_a = a2;
        mul_b = {y_q[SampleBits-1], y_q};
      end
      S_YY: begin
        mul_a = {{18{y_q[SampleBits-1]}}, y_q};
        mul_b = {y_q[SampleBits-1], y_q};
      end
      default: ;
    endcase
  end
  assign mul_p = ProdBits'(mul_a) * ProdBits'(mul_b);

  assign e_new = sum_sat(rd_word.energy, prod_q[30:0]);
  assign wr_en = (state_q == S_WR);
  assign wr_word = '{z1: z1n_q, z2: z2n_q, energy: e_new};
  assign finish = (state_q == S_WR) && (band_q == BandBits'(Bands - 1));
  assign load_out = out_pend_q && (!out_valid_q || out_ready_i);

  assign in_ready_o = (state_q == S_IDLE) && !out_pend_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o = out_q;

  // sequencer, accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_pend_q <= 1'b0;
      band_q <= '0;
      valid_q <= '0;
      total_q <= '0;
      peak_q <= '0;
      count_q <= '0;
      out_valid_q <= 1'b0;
      blk_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !load_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (load_out) begin
            out_q.total_square_sum <= total_q;
            out_q.peak_magnitude <= peak_q;
            out_q.bass_square_sum <= esum_q[0];
            out_q.mid_square_sum <= esum_q[1];
            out_q.high_square_sum <= esum_q[2];
            out_q.sample_count <= count_q;
            out_valid_q <= 1'b1;
            out_pend_q <= 1'b0;
            total_q <= '0;
            peak_q <= '0;
            count_q <= '0;
            valid_q <= '0;
          end else if (in_valid_i && in_ready_o) begin
            x_q <= mono;
            mag_q <= mono_abs[SampleBits-1:0];
            blk_q <= in_beat_i.block_end;
            state_q <= S_TOT;
          end
        end
        S_TOT: begin
          prod_q <= mul_p;
          if (mag_q > peak_q) peak_q <= mag_q;
          if (count_q != {CountBits{1'b1}}) count_q <= count_q + 1'b1;
          band_q <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          if (band_q == '0) total_q <= sum_sat(total_q, prod_q[30:0]);
          prod_q <= mul_p;
          state_q <= S_ACC;
        end
        S_ACC: begin
          bx_q <= prod_q;
          y_q <= round_sample(64'(prod_q) + 64'(rd_word.z1));
          state_q <= S_A1;
        end
        S_A1: begin
          prod_q <= mul_p;
          state_q <= S_A2;
        end
        S_A2: begin
          z1n_q <= clamp_state(52'(rd_word.z2) - 52'(prod_q));
          prod_q <= mul_p;
          state_q <= S_YY;
        end
        S_YY: begin
          z2n_q <= clamp_state(-52'(bx_q) - 52'(prod_q));
          prod_q <= mul_p;
          state_q <= S_WR;
        end
        S_WR: begin
          valid_q[band_q] <= 1'b1;
          esum_q[band_q] <= e_new;
          if (finish) begin
            band_q <= '0;
            state_q <= S_OUT_DUMMY;
            if (blk_q) out_pend_q <= 1'b1;
          end else begin
            band_q <= band_q + 1'b1;
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // an accepted beat keeps the input side closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while busy");

  // the band index never leaves the memory range
  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    band_q <= BandBits'(Bands - 1))
    else $error("band index out of range");

  // a loaded result clears the block state and shows up at the output
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && load_out) |=> (out_valid_o && valid_q == '0 && count_q == '0))
    else $error("result load did not clear block state");

  // a pending result keeps new samples out
  a_pend_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pend_q |-> !in_ready_o)
    else $error("sample accepted with a result pending");
endmodule

### hdl/tbem_ram.sv
// generic single write port ram with a registered read port
module tbem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/tbem_cfg_regs.sv
// configuration register file of the energy meter
module tbem_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [tbem_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [tbem_pkg::CfgDataBits-1:0]    cfg_data_i,
  output tbem_pkg::cfg_t                      cfg_o
);
  import tbem_pkg::*;

  cfg_t cfg_q;

  // register writes, decoded by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_t'{channel_count: 2'd1, gain: '0, cos: '0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CHANNELS:  cfg_q.channel_count <= cfg_data_i[1:0];
        CFG_BASS_GAIN: cfg_q.gain[0] <= cfg_data_i[29:0];
        CFG_BASS_COS:  cfg_q.cos[0] <= cfg_data_i;
        CFG_MID_GAIN:  cfg_q.gain[1] <= cfg_data_i[29:0];
        CFG_MID_COS:   cfg_q.cos[1] <= cfg_data_i;
        CFG_HIGH_GAIN: cfg_q.gain[2] <= cfg_data_i[29:0];
        CFG_HIGH_COS:  cfg_q.cos[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;
endmodule
